/* src/ptwa_pkg.sv */
// shared types and codes for the peer table with aging
`timescale 1ns / 1ps

package ptwa_pkg;

  // field widths
  localparam int ADDR_W   = 48;
  localparam int TIME_W   = 32;
  localparam int CAPS_W   = 16;
  localparam int INDEX_W  = 4;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 5;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 120;

  // request kinds
  localparam logic [ACTION_W-1:0] ACT_UPSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PRUNE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd6;

  // stale limit after reset
  localparam logic [TIME_W-1:0] STALE_RESET = 32'd5000;

  // one table slot
  typedef struct packed {
    logic [CAPS_W-1:0] caps;
    logic [TIME_W-1:0] seen;
    logic [ADDR_W-1:0] addr;
  } entry_t;

endpackage

/* src/peer_table_with_aging_core.sv */
// peer table with aging: sequencer, slot memory and removed-entry queue
// upsert and find scan the stored peers and stop early on a match; an upsert miss inserts
//   a new peer; get reads one slot by index; prune checks each slot and moves the last peer
//   into a freed slot; each request then sweeps the capability mask and emits the closing result
// one transaction at a time: a new request is taken only in idle, after the last result is taken
// reset: synchronous active low; table empty, stale limit 5000, slot contents left as they are
`timescale 1ns / 1ps

module peer_table_with_aging_core #(
  parameter int ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: peer_address, seen_time, capability_mask, now_time, entry_index, zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ptwa_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: action
  input  logic [ptwa_pkg::ACTION_W-1:0]        in_tuser,
  // out_tdata: out_address, out_seen_time, out_capabilities, peer_total,
  //   combined_capabilities, zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ptwa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: status
  output logic [ptwa_pkg::STATUS_W-1:0]        out_tuser,
  output logic                                 out_tlast,
  // stale limit write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ptwa_pkg::TIME_W-1:0]          cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_GET_RD  = 4'd2;
  localparam logic [3:0] S_GET_LD  = 4'd3;
  localparam logic [3:0] S_PR_RD   = 4'd4;
  localparam logic [3:0] S_PR_CHK  = 4'd5;
  localparam logic [3:0] S_PR_MV   = 4'd6;
  localparam logic [3:0] S_OR      = 4'd7;
  localparam logic [3:0] S_EM_RD   = 4'd8;
  localparam logic [3:0] S_EM_LD   = 4'd9;
  localparam logic [3:0] S_EM_WAIT = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0] state_r, state_nxt;

  // latched request
  logic [ptwa_pkg::ACTION_W-1:0] act_r, act_nxt;
  logic [ptwa_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ptwa_pkg::TIME_W-1:0]   seen_r, seen_nxt;
  logic [ptwa_pkg::CAPS_W-1:0]   caps_r, caps_nxt;
  logic [ptwa_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [ptwa_pkg::INDEX_W-1:0]  idx_r, idx_nxt;

  // table control
  logic [ptwa_pkg::TIME_W-1:0] stale_r, stale_nxt;
  logic [CW-1:0]               occ_r, occ_nxt;
  logic [CW-1:0]               scan_i_r, scan_i_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               pidx_r, pidx_nxt;
  logic [CW-1:0]               rq_cnt_r, rq_cnt_nxt;
  logic [ptwa_pkg::CAPS_W-1:0] comb_r, comb_nxt;

  // final result of the transaction
  logic [ptwa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  ptwa_pkg::entry_t              res_entry_r, res_entry_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [ptwa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  ptwa_pkg::entry_t              out_entry_r, out_entry_nxt;
  logic                          out_last_r, out_last_nxt;

  // slot memory and removed-entry queue
  ptwa_pkg::entry_t slot_mem [ENTRIES];
  ptwa_pkg::entry_t rq_mem   [ENTRIES];
  ptwa_pkg::entry_t rd_data_r;
  ptwa_pkg::entry_t rq_rd_r;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  ptwa_pkg::entry_t mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic             rq_we;
  logic [AW-1:0]    rq_waddr;
  logic [AW-1:0]    rq_raddr;

  // shared compare and subtract unit
  logic [ptwa_pkg::TIME_W-1:0] age;
  logic                        stale_hit;
  logic                        addr_hit;
  logic                        get_ok;
  logic [CW-1:0]               last_slot;
  logic [CW+4:0]               total_w;

  assign age       = now_r - rd_data_r.seen;
  assign stale_hit = age > stale_r;
  assign addr_hit  = pend_r && (rd_data_r.addr == addr_r);
  assign get_ok    = {{CW{1'b0}}, idx_r} < {4'b0000, occ_r};
  assign last_slot = occ_r - CW'(1);
  assign total_w   = {5'b00000, occ_r};

  // handshake and payload ports
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, comb_r, total_w[4:0], out_entry_r.caps,
                       out_entry_r.seen, out_entry_r.addr};

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    addr_nxt       = addr_r;
    seen_nxt       = seen_r;
    caps_nxt       = caps_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    stale_nxt      = stale_r;
    occ_nxt        = occ_r;
    scan_i_nxt     = scan_i_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    rq_cnt_nxt     = rq_cnt_r;
    comb_nxt       = comb_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = pidx_r;
    mem_wdata      = rd_data_r;
    mem_raddr      = AW'(scan_i_r);
    rq_we          = 1'b0;
    rq_waddr       = AW'(rq_cnt_r);
    rq_raddr       = AW'(scan_i_r);

    // stale limit write
    if (cfg_valid) begin
      stale_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt       = in_tuser;
          addr_nxt      = in_tdata[47:0];
          seen_nxt      = in_tdata[79:48];
          caps_nxt      = in_tdata[95:80];
          now_nxt       = in_tdata[127:96];
          idx_nxt       = in_tdata[131:128];
          scan_i_nxt    = '0;
          pend_nxt      = 1'b0;
          rq_cnt_nxt    = '0;
          comb_nxt      = '0;
          res_entry_nxt = '0;
          case (in_tuser)
            ptwa_pkg::ACT_UPSERT: state_nxt = S_SCAN;
            ptwa_pkg::ACT_FIND:   state_nxt = S_SCAN;
            ptwa_pkg::ACT_PRUNE:  state_nxt = S_PR_RD;
            ptwa_pkg::ACT_GET:    state_nxt = S_GET_RD;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end

      // address search, one read issued per cycle, compare in the cycle after
      S_SCAN: begin
        if (addr_hit) begin
          pend_nxt   = 1'b0;
          scan_i_nxt = '0;
          state_nxt  = S_OR;
          if (act_r == ptwa_pkg::ACT_UPSERT) begin
            mem_we         = 1'b1;
            mem_waddr      = pidx_r;
            mem_wdata      = '{caps: caps_r, seen: seen_r, addr: addr_r};
            res_status_nxt = ptwa_pkg::ST_UPDATED;
          end else begin
            res_status_nxt = ptwa_pkg::ST_FOUND;
            res_entry_nxt  = rd_data_r;
          end
        end else if (scan_i_r == occ_r) begin
          pend_nxt   = 1'b0;
          scan_i_nxt = '0;
          state_nxt  = S_OR;
          if (act_r == ptwa_pkg::ACT_UPSERT) begin
            if (occ_r == CW'(ENTRIES)) begin
              res_status_nxt = ptwa_pkg::ST_FULL;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = AW'(occ_r);
              mem_wdata      = '{caps: caps_r, seen: seen_r, addr: addr_r};
              occ_nxt        = occ_r + CW'(1);
              res_status_nxt = ptwa_pkg::ST_INSERTED;
            end
          end else begin
            res_status_nxt = ptwa_pkg::ST_MISSING;
          end
        end else begin
          mem_raddr  = AW'(scan_i_r);
          pidx_nxt   = AW'(scan_i_r);
          scan_i_nxt = scan_i_r + CW'(1);
          pend_nxt   = 1'b1;
        end
      end

      // read by index
      S_GET_RD: begin
        mem_raddr = AW'(idx_r);
        state_nxt = S_GET_LD;
      end

      S_GET_LD: begin
        if (get_ok) begin
          res_status_nxt = ptwa_pkg::ST_FOUND;
          res_entry_nxt  = rd_data_r;
        end else begin
          res_status_nxt = ptwa_pkg::ST_MISSING;
        end
        scan_i_nxt = '0;
        pend_nxt   = 1'b0;
        state_nxt  = S_OR;
      end

      // prune walk
      S_PR_RD: begin
        if (scan_i_r == occ_r) begin
          res_status_nxt = ptwa_pkg::ST_DONE;
          scan_i_nxt     = '0;
          pend_nxt       = 1'b0;
          state_nxt      = S_OR;
        end else begin
          mem_raddr = AW'(scan_i_r);
          state_nxt = S_PR_CHK;
        end
      end

      S_PR_CHK: begin
        if (stale_hit) begin
          rq_we      = 1'b1;
          rq_waddr   = AW'(rq_cnt_r);
          rq_cnt_nxt = rq_cnt_r + CW'(1);
          occ_nxt    = last_slot;
          if (last_slot != scan_i_r) begin
            mem_raddr = AW'(last_slot);
            state_nxt = S_PR_MV;
          end else begin
            state_nxt = S_PR_RD;
          end
        end else begin
          scan_i_nxt = scan_i_r + CW'(1);
          state_nxt  = S_PR_RD;
        end
      end

      // last entry fills the freed slot, then the slot is checked again
      S_PR_MV: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(scan_i_r);
        mem_wdata = rd_data_r;
        state_nxt = S_PR_RD;
      end

      // capability mask sweep over the remaining entries
      S_OR: begin
        if (pend_r) begin
          comb_nxt = comb_r | rd_data_r.caps;
        end
        if (scan_i_r == occ_r) begin
          pend_nxt   = 1'b0;
          scan_i_nxt = '0;
          state_nxt  = S_EM_RD;
        end else begin
          mem_raddr  = AW'(scan_i_r);
          scan_i_nxt = scan_i_r + CW'(1);
          pend_nxt   = 1'b1;
        end
      end

      // queued removals first, then the closing result
      S_EM_RD: begin
        if (scan_i_r == rq_cnt_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = res_entry_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          rq_raddr  = AW'(scan_i_r);
          state_nxt = S_EM_LD;
        end
      end

      S_EM_LD: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ptwa_pkg::ST_REMOVED;
        out_entry_nxt  = rq_rd_r;
        out_last_nxt   = 1'b0;
        scan_i_nxt     = scan_i_r + CW'(1);
        state_nxt      = S_EM_WAIT;
      end

      S_EM_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_EM_RD;
        end
      end

      S_FIN: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stale_r     <= ptwa_pkg::STALE_RESET;
      occ_r       <= '0;
      scan_i_r    <= '0;
      pend_r      <= 1'b0;
      rq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stale_r     <= stale_nxt;
      occ_r       <= occ_nxt;
      scan_i_r    <= scan_i_nxt;
      pend_r      <= pend_nxt;
      rq_cnt_r    <= rq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    addr_r       <= addr_nxt;
    seen_r       <= seen_nxt;
    caps_r       <= caps_nxt;
    now_r        <= now_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    comb_r       <= comb_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= slot_mem[mem_raddr];
  end

  // removed-entry queue, registered read
  always_ff @(posedge clk) begin
    if (rq_we) begin
      rq_mem[rq_waddr] <= rd_data_r;
    end
    rq_rd_r <= rq_mem[rq_raddr];
  end

endmodule

/* tb/testbench.sv */
// testbench for the peer table with aging core, checked result by result against a table model
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS       = 16;
  localparam int PEER_POOL   = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  // result field offsets inside out_tdata
  localparam int SEEN_LO  = ptwa_pkg::ADDR_W;
  localparam int CAPS_LO  = SEEN_LO + ptwa_pkg::TIME_W;
  localparam int TOTAL_LO = CAPS_LO + ptwa_pkg::CAPS_W;
  localparam int COMB_LO  = TOTAL_LO + ptwa_pkg::TOTAL_W;

  // one predicted result transaction
  typedef struct {
    logic [ptwa_pkg::STATUS_W-1:0] status;
    logic [ptwa_pkg::ADDR_W-1:0]   addr;
    logic [ptwa_pkg::TIME_W-1:0]   seen;
    logic [ptwa_pkg::CAPS_W-1:0]   caps;
    logic [ptwa_pkg::TOTAL_W-1:0]  total;
    logic [ptwa_pkg::CAPS_W-1:0]   combined;
    logic                          last;
  } peer_result_t;

  // shadow peer table and the queue of results still owed by the block
  class peer_table_scoreboard;
    logic [ptwa_pkg::ADDR_W-1:0] slot_addr [SLOTS];
    logic [ptwa_pkg::TIME_W-1:0] slot_seen [SLOTS];
    logic [ptwa_pkg::CAPS_W-1:0] slot_caps [SLOTS];
    int                          peer_count;
    logic [ptwa_pkg::TIME_W-1:0] stale_limit;
    peer_result_t                awaited [$];
    int                          mismatches;

    function new();
      peer_count  = 0;
      stale_limit = ptwa_pkg::STALE_RESET;
      mismatches  = 0;
    endfunction

    function int find_slot(logic [ptwa_pkg::ADDR_W-1:0] addr);
      for (int i = 0; i < peer_count; i++) begin
        if (slot_addr[i] == addr) return i;
      end
      return -1;
    endfunction

    function peer_result_t blank(logic [ptwa_pkg::STATUS_W-1:0] status);
      peer_result_t r;
      r.status   = status;
      r.addr     = '0;
      r.seen     = '0;
      r.caps     = '0;
      r.total    = '0;
      r.combined = '0;
      r.last     = 1'b0;
      return r;
    endfunction

    function peer_result_t slot_result(logic [ptwa_pkg::STATUS_W-1:0] status, int slot);
      peer_result_t r;
      r      = blank(status);
      r.addr = slot_addr[slot];
      r.seen = slot_seen[slot];
      r.caps = slot_caps[slot];
      return r;
    endfunction

    // apply one accepted request to the shadow table and queue its results
    function void note_request(logic [ptwa_pkg::ACTION_W-1:0] action,
                               logic [ptwa_pkg::ADDR_W-1:0] addr,
                               logic [ptwa_pkg::TIME_W-1:0] seen,
                               logic [ptwa_pkg::CAPS_W-1:0] caps,
                               logic [ptwa_pkg::TIME_W-1:0] now,
                               logic [ptwa_pkg::INDEX_W-1:0] idx);
      peer_result_t run [$];
      peer_result_t r;
      int           hit;
      int           i;
      int           tail;
      logic [ptwa_pkg::TIME_W-1:0] age;
      logic [ptwa_pkg::CAPS_W-1:0] all_caps;
      case (action)
        ptwa_pkg::ACT_UPSERT: begin
          hit = find_slot(addr);
          if (hit >= 0) begin
            slot_seen[hit] = seen;
            slot_caps[hit] = caps;
            run.push_back(blank(ptwa_pkg::ST_UPDATED));
          end else if (peer_count >= SLOTS) begin
            run.push_back(blank(ptwa_pkg::ST_FULL));
          end else begin
            slot_addr[peer_count] = addr;
            slot_seen[peer_count] = seen;
            slot_caps[peer_count] = caps;
            peer_count++;
            run.push_back(blank(ptwa_pkg::ST_INSERTED));
          end
        end
        ptwa_pkg::ACT_PRUNE: begin
          // a removed slot takes the last entry and is checked again
          i = 0;
          while (i < peer_count) begin
            age = now - slot_seen[i];
            if (age > stale_limit) begin
              tail = peer_count - 1;
              run.push_back(slot_result(ptwa_pkg::ST_REMOVED, i));
              slot_addr[i] = slot_addr[tail];
              slot_seen[i] = slot_seen[tail];
              slot_caps[i] = slot_caps[tail];
              peer_count = tail;
            end else begin
              i++;
            end
          end
          run.push_back(blank(ptwa_pkg::ST_DONE));
        end
        ptwa_pkg::ACT_FIND: begin
          hit = find_slot(addr);
          if (hit >= 0) run.push_back(slot_result(ptwa_pkg::ST_FOUND, hit));
          else run.push_back(blank(ptwa_pkg::ST_MISSING));
        end
        default: begin
          if (int'(idx) < peer_count) run.push_back(slot_result(ptwa_pkg::ST_FOUND, int'(idx)));
          else run.push_back(blank(ptwa_pkg::ST_MISSING));
        end
      endcase
      // totals reflect the table once the whole request is done
      all_caps = '0;
      for (int k = 0; k < peer_count; k++) all_caps |= slot_caps[k];
      for (int k = 0; k < run.size(); k++) begin
        r          = run[k];
        r.total    = ptwa_pkg::TOTAL_W'(peer_count);
        r.combined = all_caps;
        r.last     = (k == run.size() - 1);
        awaited.push_back(r);
      end
    endfunction

    task report(string what);
      if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // compare one result transaction with the oldest prediction
    task check_result(logic [ptwa_pkg::STATUS_W-1:0] status,
                      logic [ptwa_pkg::OUT_TDATA_W-1:0] data, logic last);
      peer_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending, status %0d", status));
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status)
        report($sformatf("status got %0d want %0d", status, want.status));
      if (data[0 +: ptwa_pkg::ADDR_W] !== want.addr)
        report($sformatf("address got %h want %h", data[0 +: ptwa_pkg::ADDR_W], want.addr));
      if (data[SEEN_LO +: ptwa_pkg::TIME_W] !== want.seen)
        report($sformatf("seen time got %h want %h", data[SEEN_LO +: ptwa_pkg::TIME_W],
                         want.seen));
      if (data[CAPS_LO +: ptwa_pkg::CAPS_W] !== want.caps)
        report($sformatf("capabilities got %h want %h", data[CAPS_LO +: ptwa_pkg::CAPS_W],
                         want.caps));
      if (data[TOTAL_LO +: ptwa_pkg::TOTAL_W] !== want.total)
        report($sformatf("peer total got %0d want %0d", data[TOTAL_LO +: ptwa_pkg::TOTAL_W],
                         want.total));
      if (data[COMB_LO +: ptwa_pkg::CAPS_W] !== want.combined)
        report($sformatf("combined caps got %h want %h", data[COMB_LO +: ptwa_pkg::CAPS_W],
                         want.combined));
      if (last !== want.last)
        report($sformatf("tlast got %b want %b", last, want.last));
    endtask
  endclass

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [ptwa_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [ptwa_pkg::ACTION_W-1:0]    in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [ptwa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [ptwa_pkg::STATUS_W-1:0]    out_tuser;
  logic                             out_tlast;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [ptwa_pkg::TIME_W-1:0]      cfg_data   = '0;

  peer_table_scoreboard        ledger;
  logic [ptwa_pkg::ADDR_W-1:0] known_peers [PEER_POOL];
  logic [ptwa_pkg::TIME_W-1:0] wall_clock;
  int                          age_span;
  int                          send_idle_pct = 36;
  int                          recv_idle_pct = 88;
  int                          hold_request  = 0;

  peer_table_with_aging_core #(.ENTRIES(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random backpressure, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // every result transaction is checked
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_result(out_tuser, out_tdata, out_tlast);
  end

  // watchdog
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one request and note it once accepted
  task automatic send_request(input logic [ptwa_pkg::ACTION_W-1:0] action,
                              input logic [ptwa_pkg::ADDR_W-1:0] addr,
                              input logic [ptwa_pkg::TIME_W-1:0] seen,
                              input logic [ptwa_pkg::CAPS_W-1:0] caps,
                              input logic [ptwa_pkg::TIME_W-1:0] now,
                              input logic [ptwa_pkg::INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= ptwa_pkg::IN_TDATA_W'({idx, now, caps, seen, addr});
    do @(posedge clk); while (!in_tready);
    ledger.note_request(action, addr, seen, caps, now, idx);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ptwa_pkg::TIME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.stale_limit = value;
  endtask

  // mostly known peers and plausible times, some fully random values
  task automatic random_request();
    int                            pick;
    logic [ptwa_pkg::ACTION_W-1:0] action;
    logic [ptwa_pkg::ADDR_W-1:0]   addr;
    logic [ptwa_pkg::TIME_W-1:0]   seen;
    logic [ptwa_pkg::TIME_W-1:0]   now;
    pick = $urandom_range(0, 99);
    if (pick < 45) action = ptwa_pkg::ACT_UPSERT;
    else if (pick < 55) action = ptwa_pkg::ACT_PRUNE;
    else if (pick < 80) action = ptwa_pkg::ACT_FIND;
    else action = ptwa_pkg::ACT_GET;
    wall_clock += $urandom_range(0, 400);
    if ($urandom_range(0, 9) == 0) addr = ptwa_pkg::ADDR_W'({$urandom, $urandom});
    else addr = known_peers[$urandom_range(0, PEER_POOL - 1)];
    if ($urandom_range(0, 7) == 0) seen = $urandom;
    else if ($urandom_range(0, 3) == 0) seen = wall_clock;
    else seen = wall_clock - $urandom_range(0, 3 * age_span);
    if ($urandom_range(0, 9) == 0) now = $urandom;
    else now = wall_clock;
    send_request(action, addr, seen, ptwa_pkg::CAPS_W'($urandom_range(0, 65535)), now,
                 ptwa_pkg::INDEX_W'($urandom_range(0, 15)));
  endtask

  initial begin : main
    ledger = new();
    foreach (known_peers[i]) known_peers[i] = ptwa_pkg::ADDR_W'({$urandom, $urandom});
    wall_clock = $urandom;
    age_span   = 2000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, extreme addresses, update, hit and miss, read past the end
    send_request(ptwa_pkg::ACT_GET, '0, '0, '0, '0, 4'd0);
    send_request(ptwa_pkg::ACT_FIND, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0);
    send_request(ptwa_pkg::ACT_PRUNE, '0, '0, '0, 32'd0, '0);
    send_request(ptwa_pkg::ACT_UPSERT, 48'h0, 32'h0, 16'h0, '0, '0);
    send_request(ptwa_pkg::ACT_UPSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                 32'hFFFF_FFFF, 4'hF);
    send_request(ptwa_pkg::ACT_UPSERT, 48'h0, 32'd100, 16'h0001, '0, '0);
    send_request(ptwa_pkg::ACT_FIND, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0);
    send_request(ptwa_pkg::ACT_FIND, 48'h0000_0000_0001, '0, '0, '0, '0);
    send_request(ptwa_pkg::ACT_GET, '0, '0, '0, '0, 4'd1);
    send_request(ptwa_pkg::ACT_GET, '0, '0, '0, '0, 4'd2);
    // fill to capacity, then one more new peer is dropped
    for (int i = 0; i < 14; i++)
      send_request(ptwa_pkg::ACT_UPSERT, known_peers[i], 32'd4995 + i,
                   ptwa_pkg::CAPS_W'(1 << i), '0, '0);
    send_request(ptwa_pkg::ACT_UPSERT, known_peers[14], 32'd1, 16'h8000, '0, '0);
    send_request(ptwa_pkg::ACT_GET, '0, '0, '0, '0, 4'd15);
    // stale entries, a wrapped age, and one sitting exactly on the limit
    send_request(ptwa_pkg::ACT_PRUNE, '0, '0, '0, 32'd10000, '0);

    // phase one: slow receiver, with one long hold-off
    wait_for_results();
    write_limit($urandom_range(1000, 4000));
    for (int n = 0; n < 50; n++) begin
      if (n == 20) hold_request = 400;
      random_request();
    end

    // phase two: slow sender, prune drops anything with nonzero age
    wait_for_results();
    send_idle_pct = 88;
    recv_idle_pct = 36;
    age_span      = 50;
    write_limit(32'd0);
    for (int n = 0; n < 50; n++) random_request();

    // phase three: no idling, nothing ever stale, then a random limit
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    age_span      = 2000;
    write_limit(32'hFFFF_FFFF);
    for (int n = 0; n < 28; n++) random_request();
    wait_for_results();
    write_limit($urandom);
    for (int n = 0; n < 25; n++) random_request();

    wait_for_results();
    repeat (200) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
